// File: sv/ascii_to_unsigned_parser_assert.svh
// Assertion macros shared by the parser checker.
`ifndef ASCII_TO_UNSIGNED_PARSER_ASSERT_SVH
`define ASCII_TO_UNSIGNED_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define ACP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acp assertion failed");

// Next-cycle implication, disabled during reset.
`define ACP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acp assertion failed");

// Next-cycle implication that also holds through reset.
`define ACP_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("acp assertion failed");

`endif

// File: sv/acp_pkg.sv
// Package: constants, codes and shared types of the ASCII-to-unsigned parser.
package acp_pkg;

  localparam int unsigned POSITION_BITS_DEF = 16;
  localparam int unsigned MAX_BASE          = 36;

  localparam logic [5:0] RADIX_RESET = 6'd10;
  localparam logic [5:0] BASE_DEC    = 6'd10;
  localparam logic [5:0] BASE_OCT    = 6'd8;
  localparam logic [5:0] BASE_HEX    = 6'd16;
  localparam logic [5:0] BASE_AUTO   = 6'd0;
  localparam logic [5:0] BASE_BAD    = 6'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BADBASE = 2'd1;
  localparam logic [1:0] ST_WRAP    = 2'd2;
  localparam logic [1:0] ST_UNUSED  = 2'd3;

  // One multiply-accumulate step
  typedef struct packed {
    logic        is_digit;  // character is a digit below the base
    logic [63:0] sum;       // acc * base + digit, modulo 2^64
    logic        wrap;      // step overflowed 64 bits
  } mac_t;

endpackage

// File: sv/ascii_to_unsigned_parser.sv
// Top level: streaming strtoul-style ASCII to unsigned converter.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | input     | in_valid / in_stall  | char_code, start_req
//  out     | output    | out_valid / out_stall| value, end_offset, status
//  cfg     | input     | cfg_wr_en            | cfg_wr_data (radix)
//
// One character per cycle while in_stall is low: each transfer is decoded and folded into the
// accumulator (one 64x6 multiply plus add) in the cycle it is accepted.
// A finished number is loaded into the result register at the edge that
// accepts its stopping character; out_valid is high from the next cycle.
// in_stall rises only while a result is held and out_stall is high.
// rst (synchronous) returns to idle, radix to 10, and drops any result.
module ascii_to_unsigned_parser #(
  parameter int unsigned POSITION_BITS = acp_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [5:0]  cfg_wr_data,
  // character input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        start_req,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [15:0] end_offset,
  output logic [1:0]  status
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SPACE,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

  // state
  logic [5:0]               radix;
  phase_t                   phase, phase_next;
  logic [63:0]              acc, acc_next;
  logic [5:0]               active_base, base_next;
  logic [POSITION_BITS-1:0] position, pos_next;
  logic                     wrapped, wrapped_next;

  // view of state after a start character resets it
  phase_t                   ph_c;
  logic [63:0]              acc_c;
  logic [5:0]               base_c, base_d;
  logic [POSITION_BITS-1:0] pos_c, pos_adv;
  logic                     wr_c;

  logic                     accept, emit;
  logic [63:0]              res_value;
  logic [15:0]              res_offset;
  logic [1:0]               res_status;
  logic [31:0]              pos_wide;
  logic                     is_space, bad_radix;
  acp_pkg::mac_t            mac;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign bad_radix = (radix == acp_pkg::BASE_BAD) || (32'(radix) > acp_pkg::MAX_BASE);
  assign is_space  = (char_code == acp_pkg::CH_SPACE) ||
                     (char_code inside {[acp_pkg::CH_TAB:acp_pkg::CH_CR]});

  always_comb begin
    ph_c   = start_req ? PH_SPACE : phase;
    acc_c  = start_req ? 64'd0 : acc;
    pos_c  = start_req ? '0 : position;
    wr_c   = start_req ? 1'b0 : wrapped;
    base_c = start_req ? radix : active_base;
    // base used by a digit step this cycle
    base_d = base_c;
    if (ph_c == PH_SPACE && base_c == acp_pkg::BASE_AUTO) base_d = acp_pkg::BASE_DEC;
    if (ph_c == PH_ZERO) base_d = acp_pkg::BASE_OCT;
  end

  // saturating position advance
  assign pos_adv = (pos_c == POS_MAX) ? pos_c : pos_c + POS_ONE;

  acp_mac u_mac (
    .acc       (acc_c),
    .base      (base_d),
    .char_code (char_code),
    .res       (mac)
  );

  assign pos_wide = 32'(pos_c);

  always_comb begin
    phase_next   = ph_c;
    acc_next     = acc_c;
    base_next    = base_c;
    pos_next     = pos_c;
    wrapped_next = wr_c;
    emit         = 1'b0;
    res_value    = acc_c;
    res_offset   = (pos_wide > 32'h0000_FFFF) ? 16'hFFFF : pos_wide[15:0];
    res_status   = wr_c ? acp_pkg::ST_WRAP : acp_pkg::ST_OK;

    if (start_req && bad_radix) begin
      // invalid base: report at once, ignore the rest of the string
      emit       = 1'b1;
      phase_next = PH_IDLE;
      res_value  = 64'd0;
      res_offset = 16'd0;
      res_status = acp_pkg::ST_BADBASE;
    end else begin
      case (ph_c)
        PH_IDLE: begin
        end
        PH_SPACE, PH_ZERO, PH_DIGITS: begin
          if (ph_c == PH_SPACE && is_space) begin
            pos_next = pos_adv;
          end else if (ph_c == PH_SPACE && base_c == acp_pkg::BASE_AUTO &&
                       char_code == acp_pkg::CH_ZERO) begin
            // leading zero: octal unless an x follows
            pos_next   = pos_adv;
            phase_next = PH_ZERO;
          end else if (ph_c == PH_ZERO &&
                       (char_code == acp_pkg::CH_LX || char_code == acp_pkg::CH_UX)) begin
            base_next  = acp_pkg::BASE_HEX;
            pos_next   = pos_adv;
            phase_next = PH_DIGITS;
          end else if (char_code == acp_pkg::CH_NUL || !mac.is_digit) begin
            emit       = 1'b1;
            phase_next = PH_IDLE;
            base_next  = base_d;
          end else begin
            acc_next     = mac.sum;
            wrapped_next = wr_c | mac.wrap;
            pos_next     = pos_adv;
            base_next    = base_d;
            phase_next   = PH_DIGITS;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= acp_pkg::RADIX_RESET;
      phase       <= PH_IDLE;
      acc         <= '0;
      active_base <= '0;
      position    <= '0;
      wrapped     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) radix <= cfg_wr_data;
      if (accept) begin
        phase       <= phase_next;
        acc         <= acc_next;
        active_base <= base_next;
        position    <= pos_next;
        wrapped     <= wrapped_next;
      end
      // result register: load on emit, clear on output transfer
      if (accept && emit) begin
        out_valid  <= 1'b1;
        value      <= res_value;
        end_offset <= res_offset;
        status     <= res_status;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: sv/acp_mac.sv
// Digit decode and one multiply-accumulate step.
module acp_mac (
  input  logic [63:0]   acc,
  input  logic [5:0]    base,
  input  logic [7:0]    char_code,
  output acp_pkg::mac_t res
);

  logic        dvalid;
  logic [5:0]  digit;
  logic [69:0] prod;
  logic [64:0] sum;

  always_comb begin
    dvalid = 1'b1;
    digit  = '0;
    if (char_code inside {[acp_pkg::CH_ZERO:acp_pkg::CH_NINE]}) begin
      digit = 6'(char_code - acp_pkg::CH_ZERO);
    end else if (char_code inside {[acp_pkg::CH_UA:acp_pkg::CH_UZ]}) begin
      digit = 6'(char_code - acp_pkg::CH_UA) + 6'd10;
    end else if (char_code inside {[acp_pkg::CH_LA:acp_pkg::CH_LZ]}) begin
      digit = 6'(char_code - acp_pkg::CH_LA) + 6'd10;
    end else begin
      dvalid = 1'b0;
    end
  end

  // 64 x 6 product; high bits flag the wrap
  assign prod = 70'(acc) * 70'(base);
  assign sum  = {1'b0, prod[63:0]} + 65'(digit);

  assign res.is_digit = dvalid && (digit < base);
  assign res.sum      = sum[63:0];
  assign res.wrap     = (|prod[69:64]) | sum[64];

endmodule

// File: sv/acp_checker.sv
// Port-level checker for the parser, bound to the top level.
`include "ascii_to_unsigned_parser_assert.svh"

module acp_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wr_en,
  input logic [5:0]  cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  char_code,
  input logic        start_req,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] value,
  input logic [15:0] end_offset,
  input logic [1:0]  status
);

  `ACP_ASSERT_NOW(a_stall_needs_result, in_stall, out_valid && out_stall)
  `ACP_ASSERT_NOW(a_status_code, out_valid, status != acp_pkg::ST_UNUSED)
  `ACP_ASSERT_NOW(a_badbase_zero, out_valid && status == acp_pkg::ST_BADBASE, value == 64'd0 && end_offset == 16'd0)
  `ACP_ASSERT_NEXT(a_held_result, out_valid && out_stall, out_valid && $stable(value) && $stable(status))
  `ACP_ASSERT_NEXT_ALWAYS(a_reset_clears, rst, !out_valid)

endmodule

bind ascii_to_unsigned_parser acp_checker u_acp_checker (.*);
